[src/u16u8_pkg.sv]
package u16u8_pkg;

    // code unit classification masks and bases
    localparam logic [15:0] MASK_ONE   = 16'hFF80;
    localparam logic [15:0] MASK_TWO   = 16'hF800;
    localparam logic [15:0] MASK_SURR  = 16'hFC00;
    localparam logic [15:0] HIGH_BASE  = 16'hD800;
    localparam logic [15:0] LOW_BASE   = 16'hDC00;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    // UTF-8 lead and continuation markers
    localparam logic [7:0]  LEAD_FOUR  = 8'hF0;
    localparam logic [7:0]  LEAD_THREE = 8'hE0;
    localparam logic [7:0]  LEAD_TWO   = 8'hC0;
    localparam logic [7:0]  CONT_MARK  = 8'h80;
    localparam logic [5:0]  CONT_MASK  = 6'h3F;

    // most bytes one code unit can produce
    localparam int MAX_BYTES = 6;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_BYTES);

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] data;
        logic [CNT_W-1:0]          cnt;
        logic                      ends;
    } cmd_t;

    typedef logic [2:0][7:0] three_t;

    // three-byte form of a BMP unit, first byte at index 0
    function automatic three_t enc_three(input logic [15:0] u);
        three_t r;
        r[0] = LEAD_THREE | {4'd0, u[15:12]};
        r[1] = CONT_MARK | {2'd0, u[11:6] & CONT_MASK};
        r[2] = CONT_MARK | {2'd0, u[5:0] & CONT_MASK};
        return r;
    endfunction

endpackage

[src/utf16_to_utf8_encoder_core.sv]
// UTF-16 to UTF-8 encoder.
// Input channel (s_valid/s_ready/s_code_unit) takes one UTF-16 code unit per
// transaction; output channel (m_valid/m_ready) gives one UTF-8 byte per
// transaction, with m_run_last on the last byte of each input unit and
// m_string_end on the zero byte that a zero unit produces.
// A high surrogate yields no bytes until the next unit: a low surrogate
// completes a four-byte sequence, anything else flushes it as three bytes.
// The front classifies each unit in the cycle it is accepted and pushes a
// command of up to six bytes into a two-entry queue; the back serializes it.
// The first byte of a unit passes through a queue entry, then the output register.
// Throughput: one byte per cycle while m_ready is high and the queue holds a
// command; the byte-wide output register sets this pace.
// When m_ready is low the output byte holds, the queue fills, and s_ready
// drops once both queue entries are taken.
// Reset (aresetn low, synchronous) drops any held surrogate, empties the
// queue and clears m_valid.
module utf16_to_utf8_encoder_core import u16u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_string_end
);

    logic push, pop, empty, full;
    cmd_t push_cmd, head;

    u16u8_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_code_unit (s_code_unit),
        .q_full      (full),
        .s_ready     (s_ready),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    u16u8_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    u16u8_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_string_end (m_string_end)
    );

endmodule

[src/u16u8_front.sv]
module u16u8_front import u16u8_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic [15:0] s_code_unit,
    input  logic        q_full,
    output logic        s_ready,
    output logic        push,
    output cmd_t        push_cmd
);

    logic       held_valid_reg, held_valid_next;
    logic [9:0] held_high_reg, held_high_next;

    logic        accept;
    logic        is_low, is_high, is_pair;
    logic [20:0] cp;
    three_t      pre_bytes, new_bytes;
    logic [1:0]  new_cnt;
    logic [CNT_W-1:0] pre_cnt;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign is_low  = (s_code_unit & MASK_SURR) == LOW_BASE;
    assign is_high = (s_code_unit & MASK_SURR) == HIGH_BASE;
    assign is_pair = held_valid_reg && is_low;
    assign cp      = SUPP_BASE + {1'b0, held_high_reg, s_code_unit[9:0]};

    // classify the new unit on its own
    always_comb begin
        new_bytes = '0;
        new_cnt   = 2'd0;
        if (s_code_unit == 16'd0) begin
            new_cnt = 2'd1;
        end else if ((s_code_unit & MASK_ONE) == 16'd0) begin
            new_bytes[0] = s_code_unit[7:0];
            new_cnt      = 2'd1;
        end else if ((s_code_unit & MASK_TWO) == 16'd0) begin
            new_bytes[0] = LEAD_TWO | {3'd0, s_code_unit[10:6]};
            new_bytes[1] = CONT_MARK | {2'd0, s_code_unit[5:0]};
            new_cnt      = 2'd2;
        end else if (!is_high) begin
            new_bytes = enc_three(s_code_unit);
            new_cnt   = 2'd3;
        end
    end

    assign pre_bytes = enc_three(HIGH_BASE | {6'd0, held_high_reg});
    assign pre_cnt   = held_valid_reg ? CNT_W'(3) : CNT_W'(0);

    // assemble the command: pair, or new unit preceded by any flushed high
    always_comb begin
        push_cmd = '0;
        if (is_pair) begin
            push_cmd.data[0] = LEAD_FOUR | {5'd0, cp[20:18]};
            push_cmd.data[1] = CONT_MARK | {2'd0, cp[17:12]};
            push_cmd.data[2] = CONT_MARK | {2'd0, cp[11:6]};
            push_cmd.data[3] = CONT_MARK | {2'd0, cp[5:0]};
            push_cmd.cnt     = CNT_W'(4);
        end else begin
            if (held_valid_reg) begin
                push_cmd.data[2:0] = pre_bytes;
                push_cmd.data[5:3] = new_bytes;
            end else begin
                push_cmd.data[2:0] = new_bytes;
            end
            push_cmd.cnt  = pre_cnt + CNT_W'(new_cnt);
            push_cmd.ends = s_code_unit == 16'd0;
        end
    end

    assign push = accept && (push_cmd.cnt != '0);

    // hold or release the high surrogate
    always_comb begin
        held_valid_next = held_valid_reg;
        held_high_next  = held_high_reg;
        if (accept) begin
            held_valid_next = !is_pair && is_high;
            held_high_next  = s_code_unit[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_valid_reg <= 1'b0;
        end else begin
            held_valid_reg <= held_valid_next;
        end
        held_high_reg <= held_high_next;
    end

    a_zero_clears_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_code_unit == 16'd0) |=> !held_valid_reg)
        else $error("zero unit left a surrogate held");

    a_empty_only_on_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !push) |-> is_high)
        else $error("transaction produced no bytes without a high surrogate");

endmodule

[src/u16u8_queue.sv]
module u16u8_queue import u16u8_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign empty = cnt_reg == '0;
    assign full  = cnt_reg == QCNT_W'(QDEPTH);
    assign head  = mem[rd_ptr_reg];

    // advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

[src/u16u8_back.sv]
module u16u8_back import u16u8_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_string_end
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             end_reg, end_next;

    logic load, at_last;

    assign load    = !empty && (!valid_reg || m_ready);
    assign at_last = CNT_W'(idx_reg) == head.cnt - 1'b1;
    assign pop     = load && at_last;

    // step through the head command one byte per transaction
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        end_next   = end_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            byte_next  = head.data[idx_reg];
            last_next  = at_last;
            end_next   = at_last && head.ends;
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
        last_reg <= last_next;
        end_reg  <= end_next;
    end

    assign m_valid      = valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_run_last   = last_reg;
    assign m_string_end = end_reg;

    a_end_is_last_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && end_reg) |-> (last_reg && byte_reg == 8'd0))
        else $error("string end not on a final zero byte");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !empty |-> CNT_W'(idx_reg) < head.cnt)
        else $error("byte index beyond command length");

endmodule

[sim/utf16_to_utf8_encoder_core_test.sv]
`timescale 1ns / 100ps

module utf16_to_utf8_encoder_core_test;
    import u16u8_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_OFF_LEN  = 200;
    localparam int PRINT_CAP     = 20;

    // extremes of each length class, surrogate pairs and the flush cases
    localparam logic [15:0] DIRECTED_UNITS [24] = '{
        16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
        16'hD800, 16'hDC00,
        16'hDBFF, 16'hDFFF,
        16'hD800, 16'h0041,
        16'hDABC, 16'hD912, 16'h0000,
        16'hDC00, 16'hDFFF,
        16'hDBFF, 16'h07FF,
        16'hD800, 16'hE000,
        16'hD7FF, 16'h0000,
        16'h0000
    };

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       string_end;
    } utf8_byte_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [15:0] s_code_unit  = 16'h0000;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_run_last;
    logic        m_string_end;

    // encoder state mirrored by the predictor
    logic [9:0]  pending_high  = 10'd0;
    logic        pending_valid = 1'b0;
    utf8_byte_t  utf8_expect_q[$];

    int mismatch_count   = 0;
    int items_sent       = 0;
    int cycle_count      = 0;
    int sender_idle_pct  = 0;
    int recv_stall_pct   = 0;
    int hold_start_count = 0;
    int hold_seen_count  = 0;
    int hold_left        = 0;

    utf16_to_utf8_encoder_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_unit  (s_code_unit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_string_end (m_string_end)
    );

    always #2 aclk = ~aclk;

    // bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("utf16_to_utf8_encoder_core regression: fail");
            $finish;
        end
    end

    function automatic utf8_byte_t make_byte(input logic [7:0] b, input logic is_end);
        utf8_byte_t r;
        r.data       = b;
        r.run_last   = 1'b0;
        r.string_end = is_end;
        return r;
    endfunction

    task automatic add_three(inout utf8_byte_t seq[$], input logic [15:0] u);
        seq.push_back(make_byte(LEAD_THREE | {4'd0, u[15:12]}, 1'b0));
        seq.push_back(make_byte(CONT_MARK | {2'd0, u[11:6]}, 1'b0));
        seq.push_back(make_byte(CONT_MARK | {2'd0, u[5:0]}, 1'b0));
    endtask

    // work out the bytes one accepted code unit causes
    task automatic encode_code_unit(input logic [15:0] unit);
        utf8_byte_t seq[$];
        utf8_byte_t b;
        logic [20:0] cp;
        bit paired;
        paired = 1'b0;
        if (pending_valid) begin
            if ((unit & MASK_SURR) == LOW_BASE) begin
                cp = SUPP_BASE + {1'b0, pending_high, unit[9:0]};
                seq.push_back(make_byte(LEAD_FOUR | {5'd0, cp[20:18]}, 1'b0));
                seq.push_back(make_byte(CONT_MARK | {2'd0, cp[17:12]}, 1'b0));
                seq.push_back(make_byte(CONT_MARK | {2'd0, cp[11:6]}, 1'b0));
                seq.push_back(make_byte(CONT_MARK | {2'd0, cp[5:0]}, 1'b0));
                paired = 1'b1;
            end else begin
                add_three(seq, HIGH_BASE | {6'd0, pending_high});
            end
            pending_valid = 1'b0;
            pending_high  = 10'd0;
        end
        if (!paired) begin
            if (unit == 16'h0000) begin
                seq.push_back(make_byte(8'h00, 1'b1));
            end else if ((unit & MASK_ONE) == 16'h0000) begin
                seq.push_back(make_byte(unit[7:0], 1'b0));
            end else if ((unit & MASK_TWO) == 16'h0000) begin
                seq.push_back(make_byte(LEAD_TWO | {3'd0, unit[10:6]}, 1'b0));
                seq.push_back(make_byte(CONT_MARK | {2'd0, unit[5:0]}, 1'b0));
            end else if ((unit & MASK_SURR) == HIGH_BASE) begin
                pending_high  = unit[9:0];
                pending_valid = 1'b1;
            end else begin
                add_three(seq, unit);
            end
        end
        foreach (seq[i]) begin
            b = seq[i];
            b.run_last = (i == seq.size() - 1);
            utf8_expect_q.push_back(b);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %02h expected %02h",
                     cycle_count, field, got, want);
        mismatch_count++;
    endtask

    // predict on each input transaction, check each output transaction
    always @(posedge aclk) begin
        utf8_byte_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                encode_code_unit(s_code_unit);
            if (m_valid && m_ready) begin
                if (utf8_expect_q.size() == 0) begin
                    report_mismatch("unexpected byte", m_out_byte, 8'h00);
                end else begin
                    want = utf8_expect_q.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch("out_byte", m_out_byte, want.data);
                    if (m_run_last !== want.run_last)
                        report_mismatch("run_last", {7'd0, m_run_last},
                                        {7'd0, want.run_last});
                    if (m_string_end !== want.string_end)
                        report_mismatch("string_end", {7'd0, m_string_end},
                                        {7'd0, want.string_end});
                end
            end
        end
    end

    // drive ready: random stalls, or a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_seen_count != hold_start_count) begin
            hold_seen_count = hold_start_count;
            hold_left = HOLD_OFF_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one code unit and wait for its transaction; call at a falling edge
    task automatic send_code_unit(input logic [15:0] unit);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_code_unit <= unit;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    // drop valid so the last unit is not offered again, then switch the mix
    task automatic set_idling(input int snd_pct, input int rcv_pct);
        s_valid <= 1'b0;
        @(posedge aclk);
        sender_idle_pct = snd_pct;
        recv_stall_pct  = rcv_pct;
        @(negedge aclk);
    endtask

    // one string of mixed units, mostly well-formed, mostly zero-terminated
    task automatic send_random_string();
        int len;
        int pick;
        len = $urandom_range(1, 8);
        repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                send_code_unit(16'($urandom_range(16'h0001, 16'h007F)));
            end else if (pick < 45) begin
                send_code_unit(16'($urandom_range(16'h0080, 16'h07FF)));
            end else if (pick < 65) begin
                if ($urandom_range(1))
                    send_code_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
                else
                    send_code_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
            end else if (pick < 85) begin
                send_code_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                send_code_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end else if (pick < 90) begin
                send_code_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
            end else if (pick < 95) begin
                send_code_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end else begin
                send_code_unit(16'($urandom_range(16'h0000, 16'hFFFF)));
            end
        end
        if ($urandom_range(9) != 0)
            send_code_unit(16'h0000);
    endtask

    task automatic run_random_phase(input int target);
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
            send_random_string();
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        foreach (DIRECTED_UNITS[i])
            send_code_unit(DIRECTED_UNITS[i]);
    endtask

    task automatic test_random_no_idle();
        set_idling(0, 0);
        run_random_phase(45);
    endtask

    task automatic test_random_sender_idle();
        set_idling(45, 0);
        run_random_phase(40);
    endtask

    task automatic test_random_receiver_stall();
        set_idling(0, 45);
        run_random_phase(40);
    endtask

    task automatic test_random_both_idle();
        set_idling(11, 11);
        run_random_phase(40);
    endtask

    // hold the output off while three-byte units keep coming, so input stalls
    task automatic test_backpressure();
        set_idling(0, 0);
        fork
            begin
                @(posedge aclk);
                hold_start_count++;
            end
            begin
                repeat (12) send_code_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
                repeat (6) begin
                    send_code_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                    send_code_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
                end
                send_code_unit(16'h0000);
            end
        join
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();

        // drop valid and drain what is still owed
        set_idling(0, 0);
        while (utf8_expect_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("utf16_to_utf8_encoder_core regression: pass");
        else
            $display("utf16_to_utf8_encoder_core regression: fail");
        $finish;
    end

endmodule

[filelist.f]
src/u16u8_pkg.sv
src/u16u8_front.sv
src/u16u8_queue.sv
src/u16u8_back.sv
src/utf16_to_utf8_encoder_core.sv
sim/utf16_to_utf8_encoder_core_test.sv
